### rtl/irzl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irzl_pkg;

    localparam int unsigned SEC_PER_DAY = 86400;
    localparam int unsigned SEC_PER_MIN = 60;

    localparam int MIN_W    = 11;   // minute fields
    localparam int DLY_W    = 12;   // station delay, seconds
    localparam int USED_W   = 3;    // programs in use
    localparam int TIME_W   = 18;   // query time, seconds
    localparam int MSEC_W   = 17;   // 2047 minutes in seconds
    localparam int CFG_A_W  = 2;

    localparam int unsigned MIN_MAX = 2047;
    localparam int unsigned DLY_MAX = 4095;

    typedef enum logic [1:0] {
        OP_SET_START   = 2'd0,
        OP_SET_COUNT   = 2'd1,
        OP_SET_MINUTES = 2'd2,
        OP_QUERY       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RUN_NONE   = 3'd0,
        RUN_MANUAL = 3'd1,
        RUN_ZONE   = 3'd2,
        RUN_DELAY  = 3'd3,
        RUN_BEFORE = 3'd4,
        RUN_AFTER  = 3'd5
    } run_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_MANUAL_START  = 2'd0,
        CFG_MANUAL_LENGTH = 2'd1,
        CFG_ZONE_GAP      = 2'd2,
        CFG_PROGRAMS_USED = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [MIN_W-1:0]  manual_start;
        logic [MIN_W-1:0]  manual_length;
        logic [DLY_W-1:0]  zone_gap;
        logic [USED_W-1:0] programs_in_use;
    } cfg_t;

    typedef struct packed {
        op_t               operation;
        logic [1:0]        program_sel;
        logic [3:0]        zone_sel;
        logic [MIN_W-1:0]  load_value;
        logic [TIME_W-1:0] time_offset;
    } item_t;

    typedef struct packed {
        logic       active;
        run_t       run_type;
        logic [1:0] program_index;
        logic [3:0] zone_index;
    } result_t;

    // table write strobes; value already saturated for zone counts
    typedef struct packed {
        logic             start_we;
        logic             count_we;
        logic             minutes_we;
        logic [1:0]       prog;
        logic [3:0]       zone;
        logic [MIN_W-1:0] value;
    } load_t;

    // m * 60 = m * 64 - m * 4
    function automatic logic [MSEC_W-1:0] min_to_sec(input logic [MIN_W-1:0] m);
        return {m, 6'b000000} - MSEC_W'({m, 2'b00});
    endfunction

endpackage

`default_nettype wire

### rtl/irzl_store.sv
`timescale 1ns / 1ps
`default_nettype none

module irzl_store #(
    parameter int PROGRAM_SLOTS     = 4,
    parameter int ZONES_PER_PROGRAM = 16,
    localparam int PIW   = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1,
    localparam int CW    = $clog2(ZONES_PER_PROGRAM + 1),
    localparam int DEPTH = PROGRAM_SLOTS * ZONES_PER_PROGRAM,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire irzl_pkg::load_t            load,
    input  wire logic [PIW-1:0]             tbl_prog,
    output logic [irzl_pkg::MIN_W-1:0]      tbl_start,
    output logic [CW-1:0]                   tbl_count,
    input  wire logic [AW-1:0]              mem_addr,
    output logic [irzl_pkg::MIN_W-1:0]      mem_data
);

    logic [irzl_pkg::MIN_W-1:0] start_tbl [PROGRAM_SLOTS];
    logic [CW-1:0]              count_tbl [PROGRAM_SLOTS];
    logic [irzl_pkg::MIN_W-1:0] minutes_mem [DEPTH];
    logic [irzl_pkg::MIN_W-1:0] rd_data_reg;
    logic [AW-1:0]              wr_addr;
    logic [PIW-1:0]             wr_prog;

    assign wr_prog = PIW'(load.prog);
    assign wr_addr = AW'(int'(load.prog) * ZONES_PER_PROGRAM + int'(load.zone));

    always_ff @(posedge aclk) begin
        if (load.start_we) begin
            start_tbl[wr_prog] <= load.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PROGRAM_SLOTS; i++) begin
                count_tbl[i] <= '0;
            end
        end else if (load.count_we) begin
            count_tbl[wr_prog] <= CW'(load.value);
        end
    end

    // writes happen only while the walker is idle; the read port reads every cycle, and only the walk uses its data
    always_ff @(posedge aclk) begin
        if (load.minutes_we) begin
            minutes_mem[wr_addr] <= load.value;
        end
        rd_data_reg <= minutes_mem[mem_addr];
    end

    assign tbl_start = start_tbl[tbl_prog];
    assign tbl_count = count_tbl[tbl_prog];
    assign mem_data  = rd_data_reg;

endmodule

`default_nettype wire

### rtl/irzl_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module irzl_walk #(
    parameter int PROGRAM_SLOTS     = 4,
    parameter int ZONES_PER_PROGRAM = 16,
    localparam int PIW   = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1,
    localparam int PCW   = $clog2(PROGRAM_SLOTS + 1),
    localparam int CW    = $clog2(ZONES_PER_PROGRAM + 1),
    localparam int DEPTH = PROGRAM_SLOTS * ZONES_PER_PROGRAM,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire irzl_pkg::item_t        item,
    input  wire irzl_pkg::cfg_t         cfg,
    output irzl_pkg::load_t             load,
    output logic [PIW-1:0]              tbl_prog,
    input  wire logic [irzl_pkg::MIN_W-1:0] tbl_start,
    input  wire logic [CW-1:0]          tbl_count,
    output logic [AW-1:0]               mem_addr,
    input  wire logic [irzl_pkg::MIN_W-1:0] mem_data,
    output logic                        res_valid,
    output irzl_pkg::result_t           res,
    input  wire logic                   res_take
);

    localparam int ACC_MAX = int'(irzl_pkg::SEC_PER_DAY)
        + int'(irzl_pkg::MIN_MAX * irzl_pkg::SEC_PER_MIN) * (ZONES_PER_PROGRAM + 1)
        + int'(irzl_pkg::DLY_MAX) * ZONES_PER_PROGRAM;
    localparam int ACC_W = $clog2(ACC_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_PROG,
        ST_ZONE,
        ST_FINAL,
        ST_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [irzl_pkg::TIME_W-1:0]  t_reg, t_next;
    logic [ACC_W-1:0]             ms_reg, ms_next;
    logic [ACC_W-1:0]             me_reg, me_next;
    logic [ACC_W-1:0]             dayms_reg, dayms_next;
    logic [ACC_W-1:0]             first_reg, first_next;
    logic [ACC_W-1:0]             last_reg, last_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [PCW-1:0]               used_reg, used_next;
    logic [PCW-1:0]               p_reg, p_next;
    logic [AW-1:0]                base_reg, base_next;
    logic [CW-1:0]                zr_reg, zr_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         found_reg, found_next;
    irzl_pkg::run_t               ftype_reg, ftype_next;
    logic [PCW-1:0]               fprog_reg, fprog_next;
    logic [CW-1:0]                fzone_reg, fzone_next;
    irzl_pkg::result_t            res_reg, res_next;

    logic             accept;
    logic             prog_ok;
    logic             zone_ok;
    logic [ACC_W-1:0] t_ext;
    logic [ACC_W-1:0] start_s;
    logic [ACC_W-1:0] zend;
    logic [ACC_W-1:0] dend;
    logic [PCW-1:0]   p_inc;
    logic [CW-1:0]    zr_inc;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign prog_ok = int'(item.program_sel) < PROGRAM_SLOTS;
    assign zone_ok = int'(item.zone_sel) < ZONES_PER_PROGRAM;

    always_comb begin
        load.start_we   = accept && (item.operation == irzl_pkg::OP_SET_START) && prog_ok;
        load.count_we   = accept && (item.operation == irzl_pkg::OP_SET_COUNT) && prog_ok;
        load.minutes_we = accept && (item.operation == irzl_pkg::OP_SET_MINUTES)
                          && prog_ok && zone_ok;
        load.prog       = item.program_sel;
        load.zone       = item.zone_sel;
        if ((item.operation == irzl_pkg::OP_SET_COUNT)
                && (int'(item.load_value) > ZONES_PER_PROGRAM)) begin
            load.value = irzl_pkg::MIN_W'(ZONES_PER_PROGRAM);
        end else begin
            load.value = item.load_value;
        end
    end

    assign tbl_prog = PIW'(p_reg);
    assign zr_inc   = zr_reg + 1'b1;
    assign p_inc    = p_reg + 1'b1;
    assign mem_addr = (state_reg == ST_PROG) ? base_reg : base_reg + AW'(zr_inc);

    assign t_ext   = ACC_W'(t_reg);
    assign start_s = ACC_W'(irzl_pkg::min_to_sec(tbl_start));
    assign zend    = acc_reg + ACC_W'(irzl_pkg::min_to_sec(mem_data));
    assign dend    = zend + ACC_W'(cfg.zone_gap);

    always_comb begin
        state_next = state_reg;
        t_next     = t_reg;
        ms_next    = ms_reg;
        me_next    = me_reg;
        dayms_next = dayms_reg;
        first_next = first_reg;
        last_next  = last_reg;
        acc_next   = acc_reg;
        used_next  = used_reg;
        p_next     = p_reg;
        base_next  = base_reg;
        zr_next    = zr_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        ftype_next = ftype_reg;
        fprog_next = fprog_reg;
        fzone_next = fzone_reg;
        res_next   = res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    t_next = item.time_offset;
                    if (item.operation == irzl_pkg::OP_QUERY) begin
                        state_next = ST_INIT;
                    end else begin
                        res_next.active        = 1'b0;
                        res_next.run_type      = irzl_pkg::RUN_NONE;
                        res_next.program_index = '0;
                        res_next.zone_index    = '0;
                        state_next             = ST_DONE;
                    end
                end
            end
            ST_INIT: begin
                ms_next    = ACC_W'(irzl_pkg::min_to_sec(cfg.manual_start));
                me_next    = ACC_W'(irzl_pkg::min_to_sec(cfg.manual_start))
                             + ACC_W'(irzl_pkg::min_to_sec(cfg.manual_length));
                dayms_next = ACC_W'(irzl_pkg::SEC_PER_DAY)
                             + ACC_W'(irzl_pkg::min_to_sec(cfg.manual_start));
                first_next = ACC_W'(irzl_pkg::SEC_PER_DAY)
                             + ACC_W'(irzl_pkg::min_to_sec(cfg.manual_start));
                last_next  = '0;
                found_next = 1'b0;
                ftype_next = irzl_pkg::RUN_NONE;
                fprog_next = '0;
                fzone_next = '0;
                p_next     = '0;
                base_next  = '0;
                if (int'(cfg.programs_in_use) > PROGRAM_SLOTS) begin
                    used_next = PCW'(PROGRAM_SLOTS);
                end else begin
                    used_next = PCW'(cfg.programs_in_use);
                end
                state_next = (cfg.programs_in_use == '0) ? ST_FINAL : ST_PROG;
            end
            ST_PROG: begin
                acc_next = start_s;
                cnt_next = tbl_count;
                zr_next  = '0;
                if (start_s < first_reg) begin
                    first_next = start_s;
                end
                if (tbl_count == '0) begin
                    // empty program ends where it starts
                    if (start_s > last_reg) begin
                        last_next = start_s;
                    end
                    p_next     = p_inc;
                    base_next  = base_reg + AW'(ZONES_PER_PROGRAM);
                    state_next = (p_inc == used_reg) ? ST_FINAL : ST_PROG;
                end else begin
                    state_next = ST_ZONE;
                end
            end
            ST_ZONE: begin
                // later programs overwrite: highest slot wins
                if ((t_ext >= acc_reg) && (t_ext < zend)) begin
                    found_next = 1'b1;
                    ftype_next = irzl_pkg::RUN_ZONE;
                    fprog_next = p_reg;
                    fzone_next = zr_reg;
                end else if ((t_ext >= zend) && (t_ext < dend)) begin
                    found_next = 1'b1;
                    ftype_next = irzl_pkg::RUN_DELAY;
                    fprog_next = p_reg;
                    fzone_next = zr_reg;
                end
                acc_next = dend;
                zr_next  = zr_inc;
                if (zr_inc == cnt_reg) begin
                    if (dend > last_reg) begin
                        last_next = dend;
                    end
                    p_next     = p_inc;
                    base_next  = base_reg + AW'(ZONES_PER_PROGRAM);
                    state_next = (p_inc == used_reg) ? ST_FINAL : ST_PROG;
                end
            end
            ST_FINAL: begin
                res_next.program_index = '0;
                res_next.zone_index    = '0;
                if ((t_ext >= ms_reg) && (t_ext < me_reg)) begin
                    res_next.active   = 1'b1;
                    res_next.run_type = irzl_pkg::RUN_MANUAL;
                end else if (found_reg) begin
                    res_next.active        = 1'b1;
                    res_next.run_type      = ftype_reg;
                    res_next.program_index = 2'(fprog_reg);
                    res_next.zone_index    = 4'(fzone_reg);
                end else if ((t_ext >= me_reg) && (t_ext < first_reg)) begin
                    res_next.active   = 1'b0;
                    res_next.run_type = irzl_pkg::RUN_BEFORE;
                end else if ((t_ext >= last_reg) && (t_ext < dayms_reg)) begin
                    res_next.active   = 1'b0;
                    res_next.run_type = irzl_pkg::RUN_AFTER;
                end else begin
                    res_next.active   = 1'b0;
                    res_next.run_type = irzl_pkg::RUN_NONE;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        t_reg     <= t_next;
        ms_reg    <= ms_next;
        me_reg    <= me_next;
        dayms_reg <= dayms_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        acc_reg   <= acc_next;
        used_reg  <= used_next;
        p_reg     <= p_next;
        base_reg  <= base_next;
        zr_reg    <= zr_next;
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        ftype_reg <= ftype_next;
        fprog_reg <= fprog_next;
        fzone_reg <= fzone_next;
        res_reg   <= res_next;
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

### rtl/irrigation_zone_run_locator.sv
// Load item: the result passes through the walker's result register, then the output register.
// Query: the walker fetches the start and count of each of the first U programs,
//   U = programs in use, and reads one zone-minutes word per cycle from the
//   schedule memory for each zone that those counts cover.
// One item is in the walker at a time; the next is taken once the result moves
//   to the output register, which holds it until the result transfer.
// Reset (aresetn, synchronous, low): control, config registers and zone counts clear;
//   start and zone-minutes tables keep their contents until written.
`timescale 1ns / 1ps
`default_nettype none

module irrigation_zone_run_locator #(
    parameter int PROGRAM_SLOTS     = 4,
    parameter int ZONES_PER_PROGRAM = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // config write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [11:0] cfg_wdata,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // program_sel[1:0], zone_sel[5:2], load_value[16:6], time_offset[34:17], zero fill
    input  wire logic [39:0] s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // active[0], run_type[3:1], program_index[5:4], zone_index[9:6], zero fill
    output logic [15:0]      m_axis_tdata
);

    localparam int PIW   = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;
    localparam int CW    = $clog2(ZONES_PER_PROGRAM + 1);
    localparam int DEPTH = PROGRAM_SLOTS * ZONES_PER_PROGRAM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    irzl_pkg::cfg_t              cfg_reg;
    irzl_pkg::item_t             item;
    irzl_pkg::load_t             load;
    irzl_pkg::result_t           res;
    irzl_pkg::result_t           out_reg;
    logic                        out_valid_reg;
    logic                        res_valid;
    logic                        res_take;
    logic [PIW-1:0]              tbl_prog;
    logic [irzl_pkg::MIN_W-1:0]  tbl_start;
    logic [CW-1:0]               tbl_count;
    logic [AW-1:0]               mem_addr;
    logic [irzl_pkg::MIN_W-1:0]  mem_data;

    // Config registers; written only while the block is idle (the user's duty; the block does not enforce it).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (irzl_pkg::cfg_idx_t'(cfg_addr))
                irzl_pkg::CFG_MANUAL_START: begin
                    cfg_reg.manual_start <= cfg_wdata[irzl_pkg::MIN_W-1:0];
                end
                irzl_pkg::CFG_MANUAL_LENGTH: begin
                    cfg_reg.manual_length <= cfg_wdata[irzl_pkg::MIN_W-1:0];
                end
                irzl_pkg::CFG_ZONE_GAP: begin
                    cfg_reg.zone_gap <= cfg_wdata;
                end
                irzl_pkg::CFG_PROGRAMS_USED: begin
                    cfg_reg.programs_in_use <= cfg_wdata[irzl_pkg::USED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Unpack the input transfer.
    assign item.operation   = irzl_pkg::op_t'(s_axis_tuser);
    assign item.program_sel = s_axis_tdata[1:0];
    assign item.zone_sel    = s_axis_tdata[5:2];
    assign item.load_value  = s_axis_tdata[16:6];
    assign item.time_offset = s_axis_tdata[34:17];

    // Schedule tables: start and count per program, zone minutes in memory.
    irzl_store #(
        .PROGRAM_SLOTS     (PROGRAM_SLOTS),
        .ZONES_PER_PROGRAM (ZONES_PER_PROGRAM)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .tbl_prog  (tbl_prog),
        .tbl_start (tbl_start),
        .tbl_count (tbl_count),
        .mem_addr  (mem_addr),
        .mem_data  (mem_data)
    );

    // Sequencer: decodes loads, walks every zone of every program in use for a query.
    irzl_walk #(
        .PROGRAM_SLOTS     (PROGRAM_SLOTS),
        .ZONES_PER_PROGRAM (ZONES_PER_PROGRAM)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .item      (item),
        .cfg       (cfg_reg),
        .load      (load),
        .tbl_prog  (tbl_prog),
        .tbl_start (tbl_start),
        .tbl_count (tbl_count),
        .mem_addr  (mem_addr),
        .mem_data  (mem_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Output register: takes a finished result whenever it is empty or draining.
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_take) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_take) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_reg.zone_index, out_reg.program_index,
                            out_reg.run_type, out_reg.active};

endmodule

`default_nettype wire
